// ----- design/buddy_block_allocator_unit_macros.svh -----
// Assertion helpers shared by the allocator modules.
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bba_pkg.sv -----
package bba_pkg;

    localparam int REQ_W       = 24;
    localparam int NODE_IDX_W  = 15;
    localparam int OFF_W       = 32;
    localparam int STATUS_W    = 2;
    localparam int LEVEL_W     = 4;
    localparam int LEAF_W      = 16;
    localparam int WORD_BITS   = 32;
    localparam int WORD_SHIFT  = 5;
    localparam int BIT_W       = 5;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int REG_SEL_BIT = 2;

    localparam logic [LEVEL_W-1:0]   LEVEL_COUNT_RESET = 4'd8;
    localparam logic [LEAF_W-1:0]    LEAF_BYTES_RESET  = 16'd64;
    // Word 0 after reset: only the root (node 1) is free.
    localparam logic [WORD_BITS-1:0] ROOT_WORD         = 32'h0000_0002;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic REG_LEVEL_COUNT = 1'b0;
    localparam logic REG_LEAF_BYTES  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_BLOCK = 2'd1,
        STATUS_BAD_NODE = 2'd2
    } t_bba_status;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_SIZE,
        ST_SCAN_START,
        ST_SCAN,
        ST_TAKE,
        ST_SPLIT_RD,
        ST_SPLIT_WR,
        ST_FREE_RD,
        ST_FREE_CHK,
        ST_OFF_SIZE,
        ST_OFF_MUL,
        ST_RESULT
    } t_bba_state;

    typedef struct packed {
        logic        take;
        logic        init_write;
        logic        free_init;
        logic        size_shift;
        logic        scan_init;
        logic        scan_start;
        logic        scan_next;
        logic        scan_hit;
        logic        scan_down;
        logic        take_write;
        logic        split_write;
        logic        merge_write;
        logic        free_write;
        logic        descend;
        logic        read_node;
        logic        off_prep;
        logic        off_mul;
        logic        status_we;
        t_bba_status status_code;
        logic        load_out;
    } t_bba_cmd;

    typedef struct packed {
        logic init_last;
        logic is_free;
        logic bad_free;
        logic size_fit;
        logic lvl_is_one;
        logic hit;
        logic scan_last;
        logic k_is_one;
        logic at_target;
        logic merge;
        logic out_free;
    } t_bba_sts;

endpackage

// ----- design/bba_req_if.sv -----
interface bba_req_if;
    logic                            valid;
    logic                            ready;
    logic                            opcode;
    logic [bba_pkg::REQ_W-1:0]      request_bytes;
    logic [bba_pkg::NODE_IDX_W-1:0] free_node;

    modport source (output valid, output opcode, output request_bytes, output free_node,
                    input ready);
    modport sink   (input valid, input opcode, input request_bytes, input free_node,
                    output ready);
endinterface

// ----- design/bba_rsp_if.sv -----
interface bba_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bba_pkg::STATUS_W-1:0]   status;
    logic [bba_pkg::NODE_IDX_W-1:0] node_index;
    logic [bba_pkg::OFF_W-1:0]      byte_offset;

    modport source (output valid, output status, output node_index, output byte_offset,
                    input ready);
    modport sink   (input valid, input status, input node_index, input byte_offset,
                    output ready);
endinterface

// ----- design/bba_ctrl.sv -----
`include "buddy_block_allocator_unit_macros.svh"

module bba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bba_pkg::t_bba_sts i_sts,
    output bba_pkg::t_bba_cmd o_cmd
);

    bba_pkg::t_bba_state r_state;
    bba_pkg::t_bba_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            bba_pkg::ST_INIT: begin
                o_cmd.init_write = 1'b1;
                if (i_sts.init_last) begin
                    n_state = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = bba_pkg::ST_DISPATCH;
                end
            end
            bba_pkg::ST_DISPATCH: begin
                priority if (!i_sts.is_free) begin
                    n_state = bba_pkg::ST_SIZE;
                end else if (i_sts.bad_free) begin
                    o_cmd.status_we   = 1'b1;
                    o_cmd.status_code = bba_pkg::STATUS_BAD_NODE;
                    n_state           = bba_pkg::ST_RESULT;
                end else begin
                    o_cmd.free_init = 1'b1;
                    n_state         = bba_pkg::ST_FREE_RD;
                end
            end
            bba_pkg::ST_SIZE: begin
                // Walk up from the deepest level until the block holds the request.
                priority if (i_sts.size_fit) begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = bba_pkg::ST_SCAN_START;
                end else if (i_sts.lvl_is_one) begin
                    o_cmd.status_we   = 1'b1;
                    o_cmd.status_code = bba_pkg::STATUS_NO_BLOCK;
                    n_state           = bba_pkg::ST_RESULT;
                end else begin
                    o_cmd.size_shift = 1'b1;
                end
            end
            bba_pkg::ST_SCAN_START: begin
                o_cmd.scan_start = 1'b1;
                n_state          = bba_pkg::ST_SCAN;
            end
            bba_pkg::ST_SCAN: begin
                priority if (i_sts.hit) begin
                    o_cmd.scan_hit = 1'b1;
                    n_state        = bba_pkg::ST_TAKE;
                end else if (i_sts.scan_last && i_sts.k_is_one) begin
                    o_cmd.status_we   = 1'b1;
                    o_cmd.status_code = bba_pkg::STATUS_NO_BLOCK;
                    n_state           = bba_pkg::ST_RESULT;
                end else if (i_sts.scan_last) begin
                    o_cmd.scan_down = 1'b1;
                    n_state         = bba_pkg::ST_SCAN_START;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            bba_pkg::ST_TAKE: begin
                o_cmd.take_write = 1'b1;
                if (i_sts.at_target) begin
                    n_state = bba_pkg::ST_OFF_SIZE;
                end else begin
                    o_cmd.descend = 1'b1;
                    n_state       = bba_pkg::ST_SPLIT_RD;
                end
            end
            bba_pkg::ST_SPLIT_RD: begin
                o_cmd.read_node = 1'b1;
                n_state         = bba_pkg::ST_SPLIT_WR;
            end
            bba_pkg::ST_SPLIT_WR: begin
                o_cmd.split_write = 1'b1;
                if (i_sts.at_target) begin
                    n_state = bba_pkg::ST_OFF_SIZE;
                end else begin
                    o_cmd.descend = 1'b1;
                    n_state       = bba_pkg::ST_SPLIT_RD;
                end
            end
            bba_pkg::ST_FREE_RD: begin
                o_cmd.read_node = 1'b1;
                n_state         = bba_pkg::ST_FREE_CHK;
            end
            bba_pkg::ST_FREE_CHK: begin
                if (i_sts.merge) begin
                    o_cmd.merge_write = 1'b1;
                    n_state           = bba_pkg::ST_FREE_RD;
                end else begin
                    o_cmd.free_write = 1'b1;
                    n_state          = bba_pkg::ST_OFF_SIZE;
                end
            end
            bba_pkg::ST_OFF_SIZE: begin
                o_cmd.off_prep = 1'b1;
                n_state        = bba_pkg::ST_OFF_MUL;
            end
            bba_pkg::ST_OFF_MUL: begin
                o_cmd.off_mul     = 1'b1;
                o_cmd.status_we   = 1'b1;
                o_cmd.status_code = bba_pkg::STATUS_OK;
                n_state           = bba_pkg::ST_RESULT;
            end
            bba_pkg::ST_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = bba_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::ST_IDLE;
            end
        endcase
    end

    `BBA_ASSERT_NXT(a_accept_leaves_idle, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state != bba_pkg::ST_IDLE, "accepted request did not start work")

endmodule

// ----- design/bba_dp.sv -----
`include "buddy_block_allocator_unit_macros.svh"

module bba_dp #(
    parameter int MAX_LEVEL_COUNT = 15,
    parameter int HEADER_BYTES    = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bba_pkg::t_bba_cmd               i_cmd,
    output bba_pkg::t_bba_sts               o_sts,
    input  logic [bba_pkg::LEVEL_W-1:0]     i_levels,
    input  logic [bba_pkg::LEAF_W-1:0]      i_leaf_bytes,
    input  logic                            i_opcode,
    input  logic [bba_pkg::REQ_W-1:0]       i_request_bytes,
    input  logic [bba_pkg::NODE_IDX_W-1:0]  i_free_node,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [bba_pkg::STATUS_W-1:0]    o_status,
    output logic [bba_pkg::NODE_IDX_W-1:0]  o_node_index,
    output logic [bba_pkg::OFF_W-1:0]       o_byte_offset
);

    localparam int NW     = MAX_LEVEL_COUNT;
    localparam int AW     = (MAX_LEVEL_COUNT > bba_pkg::WORD_SHIFT) ?
                            MAX_LEVEL_COUNT - bba_pkg::WORD_SHIFT : 1;
    localparam int WORDS  = 1 << AW;
    localparam int SW     = bba_pkg::LEAF_W + MAX_LEVEL_COUNT - 1;
    localparam int PW     = MAX_LEVEL_COUNT - 1;
    localparam int NEED_W = bba_pkg::REQ_W + 1;
    localparam int CW     = (SW > NEED_W) ? SW : NEED_W;
    localparam int WB     = bba_pkg::WORD_BITS;
    localparam int LW     = bba_pkg::LEVEL_W;

    // Free map: one bit per tree node, 32 nodes per word, node n in word n/32.
    logic [WB-1:0] r_map [WORDS];

    logic [WB-1:0]                  r_rdata;
    logic [AW-1:0]                  r_echo;
    logic [AW-1:0]                  r_init_addr;
    logic                           r_op;
    logic [NEED_W-1:0]              r_need;
    logic [bba_pkg::NODE_IDX_W-1:0] r_fnode;
    logic [SW-1:0]                  r_size;
    logic [LW-1:0]                  r_lvl;
    logic [LW-1:0]                  r_k;
    logic [LW-1:0]                  r_cur;
    logic [AW-1:0]                  r_last;
    logic [NW-1:0]                  r_node;
    logic [PW-1:0]                  r_pos;
    logic [bba_pkg::OFF_W-1:0]      r_off;
    bba_pkg::t_bba_status           r_status;
    logic                           r_out_valid;
    bba_pkg::t_bba_status           r_out_status;
    logic [bba_pkg::NODE_IDX_W-1:0] r_out_node;
    logic [bba_pkg::OFF_W-1:0]      r_out_off;

    logic                 w_rd_en;
    logic [AW-1:0]        w_rd_addr;
    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    logic [WB-1:0]        w_wr_data;
    logic [WB-1:0]        w_onehot;
    logic [NW-1:0]        w_sel_node;
    logic [NW-1:0]        w_first_node;
    logic [NW-1:0]        w_last_node;
    logic [WB-1:0]        w_hit_word;
    logic [NW-1:0]        w_off_node;
    logic [SW+PW-1:0]     w_prod;
    logic                 w_ok;

    function automatic logic [WB-1:0] level_mask(input logic [LW-1:0] k);
        logic [WB-1:0] m;
        int            kk;
        kk = int'(k);
        for (int b = 0; b < WB; b++) begin
            // Levels below six share word 0; deeper levels own whole words.
            m[b] = (kk > bba_pkg::WORD_SHIFT) || ((b >> (kk - 1)) == 1);
        end
        return m;
    endfunction

    function automatic logic [bba_pkg::BIT_W-1:0] lowest_set(input logic [WB-1:0] w);
        logic [bba_pkg::BIT_W-1:0] idx;
        idx = '0;
        for (int b = WB - 1; b >= 0; b--) begin
            if (w[b]) begin
                idx = bba_pkg::BIT_W'(b);
            end
        end
        return idx;
    endfunction

    function automatic logic [LW-1:0] node_level(input logic [bba_pkg::NODE_IDX_W-1:0] n);
        logic [LW-1:0] l;
        l = '0;
        for (int b = 0; b < bba_pkg::NODE_IDX_W; b++) begin
            if (n[b]) begin
                l = LW'(b + 1);
            end
        end
        return l;
    endfunction

    function automatic logic [AW-1:0] word_of(input logic [NW-1:0] n);
        return AW'(n >> bba_pkg::WORD_SHIFT);
    endfunction

    function automatic logic [bba_pkg::BIT_W-1:0] pos_of(input logic [NW-1:0] n);
        return bba_pkg::BIT_W'(n);
    endfunction

    assign w_first_node = NW'(1) << (r_k - LW'(1));
    assign w_last_node  = w_first_node | (w_first_node - NW'(1));
    assign w_hit_word   = r_rdata & level_mask(r_k);
    assign w_off_node   = (r_op == bba_pkg::OP_FREE) ? NW'(r_fnode) : r_node;
    assign w_prod       = r_size * r_pos;
    assign w_ok         = (r_status == bba_pkg::STATUS_OK);

    always_comb begin
        w_rd_en   = i_cmd.scan_start || i_cmd.scan_next || i_cmd.read_node;
        w_rd_addr = word_of(r_node);
        if (i_cmd.scan_start) begin
            w_rd_addr = word_of(w_first_node);
        end else if (i_cmd.scan_next) begin
            w_rd_addr = r_echo + AW'(1);
        end
    end

    always_comb begin
        w_sel_node = r_node;
        if (i_cmd.merge_write) begin
            w_sel_node = r_node ^ NW'(1);
        end else if (i_cmd.split_write) begin
            w_sel_node = r_node | NW'(1);
        end
        w_onehot  = WB'(1) << pos_of(w_sel_node);
        w_wr_en   = i_cmd.init_write || i_cmd.take_write || i_cmd.split_write
                    || i_cmd.merge_write || i_cmd.free_write;
        w_wr_addr = i_cmd.init_write ? r_init_addr : word_of(r_node);
        if (i_cmd.init_write) begin
            w_wr_data = (r_init_addr == '0) ? bba_pkg::ROOT_WORD : '0;
        end else if (i_cmd.take_write || i_cmd.merge_write) begin
            w_wr_data = r_rdata & ~w_onehot;
        end else begin
            w_wr_data = r_rdata | w_onehot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_map[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_map[w_rd_addr];
            r_echo  <= w_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_addr <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.init_write) begin
                r_init_addr <= r_init_addr + AW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_op    <= i_opcode;
            r_need  <= NEED_W'(i_request_bytes) + NEED_W'(HEADER_BYTES);
            r_fnode <= i_free_node;
        end
        if (i_cmd.take) begin
            r_size <= SW'(i_leaf_bytes);
        end else if (i_cmd.size_shift) begin
            r_size <= r_size << 1;
        end else if (i_cmd.off_prep) begin
            r_size <= SW'(i_leaf_bytes) << (i_levels - r_lvl);
        end
        if (i_cmd.take) begin
            r_lvl <= i_levels;
        end else if (i_cmd.size_shift) begin
            r_lvl <= r_lvl - LW'(1);
        end else if (i_cmd.free_init) begin
            r_lvl <= node_level(r_fnode);
        end
        if (i_cmd.scan_init) begin
            r_k <= r_lvl;
        end else if (i_cmd.scan_down) begin
            r_k <= r_k - LW'(1);
        end
        if (i_cmd.scan_start) begin
            r_last <= word_of(w_last_node);
        end
        if (i_cmd.scan_hit) begin
            r_cur <= r_k;
        end else if (i_cmd.descend) begin
            r_cur <= r_cur + LW'(1);
        end
        if (i_cmd.free_init) begin
            r_node <= NW'(r_fnode);
        end else if (i_cmd.scan_hit) begin
            r_node <= NW'({r_echo, lowest_set(w_hit_word)});
        end else if (i_cmd.descend) begin
            r_node <= r_node << 1;
        end else if (i_cmd.merge_write) begin
            r_node <= r_node >> 1;
        end
        if (i_cmd.off_prep) begin
            r_pos <= PW'(w_off_node & ~(NW'(1) << (r_lvl - LW'(1))));
        end
        if (i_cmd.off_mul) begin
            r_off <= bba_pkg::OFF_W'(w_prod);
        end
        if (i_cmd.status_we) begin
            r_status <= i_cmd.status_code;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_node   <= !w_ok ? '0 :
                            (r_op == bba_pkg::OP_FREE) ? r_fnode :
                            bba_pkg::NODE_IDX_W'(r_node);
            r_out_off    <= w_ok ? r_off : '0;
        end
    end

    always_comb begin
        o_sts.init_last  = (r_init_addr == '1);
        o_sts.is_free    = (r_op == bba_pkg::OP_FREE);
        o_sts.bad_free   = (r_fnode == '0) || ({1'b0, r_fnode}
                           >= ((bba_pkg::NODE_IDX_W + 1)'(1) << i_levels));
        o_sts.size_fit   = (CW'(r_size) >= CW'(r_need));
        o_sts.lvl_is_one = (r_lvl == LW'(1));
        o_sts.hit        = |w_hit_word;
        o_sts.scan_last  = (r_echo == r_last);
        o_sts.k_is_one   = (r_k == LW'(1));
        o_sts.at_target  = (r_cur == r_lvl);
        o_sts.merge      = (r_node != NW'(1)) && r_rdata[pos_of(r_node ^ NW'(1))];
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_node_index  = r_out_node;
    assign o_byte_offset = r_out_off;

    `BBA_ASSERT_IMP(a_no_rw_collision, i_clk, i_rst_n, w_wr_en && w_rd_en, w_wr_addr != w_rd_addr, "map word read and written in one cycle")
    `BBA_ASSERT_IMP(a_scan_in_range, i_clk, i_rst_n, i_cmd.scan_next, r_echo != r_last, "scan ran past the last word of a level")
    `BBA_ASSERT_NXT(a_ok_has_node, i_clk, i_rst_n, i_cmd.load_out && w_ok, r_out_node != '0, "good result carries node zero")

endmodule

// ----- design/buddy_block_allocator_unit.sv -----
// Channel   Dir  Handshake          Beat contents
// i_req     in   valid/ready        opcode, request_bytes, free_node
// o_rsp     out  valid/ready        status, node_index, byte_offset
// APB       in   psel/penable       level_count at 0x0, leaf_bytes at 0x4
//
// Allocate takes S size steps (up to level_count), then reads W(k) map words for
// each level k searched (one word of 32 nodes per cycle through the single map
// read port, 2^(k-6) words for k > 5) and makes D splits; free makes M buddy merges.
// After reset a clearing pass writes all 2^(MAX_LEVEL_COUNT-5) map words (1024 by
// default) before the first request beat; APB writes are taken throughout.
// A result waits in an output register; the next request is taken meanwhile and
// its result is held back until that register is free.
module buddy_block_allocator_unit #(
    parameter int MAX_LEVEL_COUNT = 15,
    parameter int HEADER_BYTES    = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bba_req_if.sink                           i_req,
    bba_rsp_if.source                         o_rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bba_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bba_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bba_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [bba_pkg::LEVEL_W-1:0] r_level_count;
    logic [bba_pkg::LEAF_W-1:0]  r_leaf_bytes;
    logic [bba_pkg::LEVEL_W-1:0] w_levels;
    logic                        w_cfg_we;
    bba_pkg::t_bba_cmd           w_cmd;
    bba_pkg::t_bba_sts           w_sts;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_count <= bba_pkg::LEVEL_COUNT_RESET;
            r_leaf_bytes  <= bba_pkg::LEAF_BYTES_RESET;
        end else if (w_cfg_we) begin
            unique case (paddr[bba_pkg::REG_SEL_BIT])
                bba_pkg::REG_LEVEL_COUNT: r_level_count <= bba_pkg::LEVEL_W'(pwdata);
                bba_pkg::REG_LEAF_BYTES:  r_leaf_bytes  <= bba_pkg::LEAF_W'(pwdata);
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[bba_pkg::REG_SEL_BIT])
            bba_pkg::REG_LEVEL_COUNT: prdata = bba_pkg::APB_DATA_W'(r_level_count);
            bba_pkg::REG_LEAF_BYTES:  prdata = bba_pkg::APB_DATA_W'(r_leaf_bytes);
            default:                  prdata = '0;
        endcase
    end

    // A level count of zero behaves as one; above the built depth it saturates.
    always_comb begin
        if (r_level_count == '0) begin
            w_levels = bba_pkg::LEVEL_W'(1);
        end else if (r_level_count > bba_pkg::LEVEL_W'(MAX_LEVEL_COUNT)) begin
            w_levels = bba_pkg::LEVEL_W'(MAX_LEVEL_COUNT);
        end else begin
            w_levels = r_level_count;
        end
    end

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bba_dp #(
        .MAX_LEVEL_COUNT (MAX_LEVEL_COUNT),
        .HEADER_BYTES    (HEADER_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_levels        (w_levels),
        .i_leaf_bytes    (r_leaf_bytes),
        .i_opcode        (i_req.opcode),
        .i_request_bytes (i_req.request_bytes),
        .i_free_node     (i_req.free_node),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_status        (o_rsp.status),
        .o_node_index    (o_rsp.node_index),
        .o_byte_offset   (o_rsp.byte_offset)
    );

endmodule

// ----- sim/tb_buddy_block_allocator_unit.sv -----
module tb_buddy_block_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH_CAP    = 15;
    localparam int HEADER_BYTES = 4;
    localparam longint unsigned MAX_NEED = (1 << bba_pkg::REQ_W) - 1 + HEADER_BYTES;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int LONG_HOLD    = 600;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASES       = 11;

    localparam int PHASE_LEVELS [PHASES] = '{8, 1, 15, 3, 0, 4, 6, 11, 15, 10, 8};
    localparam int PHASE_LEAF   [PHASES] = '{64, 1, 65535, 16, 9, 0, 7, 300, 1, 65535, 64};
    localparam int PHASE_ITEMS  [PHASES] = '{260, 80, 60, 200, 40, 40, 250, 200, 80, 200, 30};

    typedef struct packed {
        logic                           opcode;
        logic [bba_pkg::REQ_W-1:0]      request_bytes;
        logic [bba_pkg::NODE_IDX_W-1:0] free_node;
    } t_req_beat;

    typedef struct packed {
        bba_pkg::t_bba_status           status;
        logic [bba_pkg::NODE_IDX_W-1:0] node_index;
        logic [bba_pkg::OFF_W-1:0]      byte_offset;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [bba_pkg::APB_ADDR_W-1:0] paddr;
    logic [bba_pkg::APB_DATA_W-1:0] pwdata;
    logic [bba_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    bba_req_if req_if();
    bba_rsp_if rsp_if();

    buddy_block_allocator_unit #(
        .MAX_LEVEL_COUNT(DEPTH_CAP),
        .HEADER_BYTES   (HEADER_BYTES)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // Shadow of the allocator: free bitmap and the two registers.
    bit                             free_map [1 << bba_pkg::NODE_IDX_W];
    logic [bba_pkg::LEVEL_W-1:0]    level_cnt_q;
    logic [bba_pkg::LEAF_W-1:0]     leaf_q;

    t_req_beat                      req_backlog [$];
    t_reply                         due_replies [$];
    logic [bba_pkg::NODE_IDX_W-1:0] held_nodes [$];

    int unsigned cycle_count = 0;
    int unsigned errors = 0;
    int unsigned replies_seen = 0;
    int unsigned send_wait;
    int unsigned reply_wait;
    bit          send_calm = 1'b0;
    bit          reply_calm = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int unsigned tree_depth();
        if (level_cnt_q == 0) return 1;
        if (level_cnt_q > DEPTH_CAP) return DEPTH_CAP;
        return level_cnt_q;
    endfunction

    function automatic logic [bba_pkg::OFF_W-1:0] block_base(int unsigned node,
                                                             int unsigned lvl,
                                                             int unsigned levels);
        longint unsigned span;
        span = 64'(leaf_q) << (levels - lvl);
        return bba_pkg::OFF_W'(span * (node - (1 << (lvl - 1))));
    endfunction

    function automatic int unsigned first_free_node(int unsigned lvl);
        for (int unsigned n = 1 << (lvl - 1); n < (1 << lvl); n++) begin
            if (free_map[n]) return n;
        end
        return 0;
    endfunction

    // Applies one request to the shadow map and returns the reply it must produce.
    function automatic t_reply serve_request(t_req_beat beat);
        int unsigned levels;
        int unsigned lvl;
        int unsigned k;
        int unsigned got;
        int unsigned n;
        int unsigned fnode;
        longint unsigned root_span;
        longint unsigned need;
        t_reply r;
        levels = tree_depth();
        r = '{status: bba_pkg::STATUS_OK, node_index: '0, byte_offset: '0};
        if (beat.opcode == bba_pkg::OP_ALLOC) begin
            root_span = 64'(leaf_q) << levels;
            need = 64'(beat.request_bytes) + HEADER_BYTES;
            lvl = 0;
            for (int l = levels; l >= 1; l--) begin
                if ((need << l) <= root_span) begin
                    lvl = l;
                    break;
                end
            end
            got = 0;
            k = 0;
            for (int j = lvl; j >= 1; j--) begin
                got = first_free_node(j);
                if (got != 0) begin
                    k = j;
                    break;
                end
            end
            if (got == 0) begin
                r.status = bba_pkg::STATUS_NO_BLOCK;
            end else begin
                // Split down to the wanted level, keeping the left half each time.
                free_map[got] = 1'b0;
                for (int unsigned j = k + 1; j <= lvl; j++) begin
                    got = got << 1;
                    free_map[got + 1] = 1'b1;
                end
                r.node_index = got;
                r.byte_offset = block_base(got, lvl, levels);
            end
        end else begin
            fnode = beat.free_node;
            if (fnode == 0 || fnode >= (1 << levels)) begin
                r.status = bba_pkg::STATUS_BAD_NODE;
            end else begin
                n = fnode;
                while (n != 1 && free_map[n ^ 1]) begin
                    free_map[n ^ 1] = 1'b0;
                    n = n >> 1;
                end
                free_map[n] = 1'b1;
                r.node_index = fnode;
                r.byte_offset = block_base(fnode, $clog2(fnode + 1), levels);
            end
        end
        return r;
    endfunction

    function automatic t_req_beat alloc_beat(longint unsigned bytes);
        return '{opcode: bba_pkg::OP_ALLOC, request_bytes: bba_pkg::REQ_W'(bytes),
                 free_node: bba_pkg::NODE_IDX_W'($urandom)};
    endfunction

    function automatic t_req_beat release_beat(int unsigned node);
        return '{opcode: bba_pkg::OP_FREE, request_bytes: bba_pkg::REQ_W'($urandom),
                 free_node: bba_pkg::NODE_IDX_W'(node)};
    endfunction

    task automatic push_beat(input t_req_beat beat);
        do @(negedge i_clk); while (req_backlog.size() >= 2);
        req_backlog.push_back(beat);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (req_backlog.size() != 0 || req_if.valid || due_replies.size() != 0);
    endtask

    task automatic write_reg(input logic reg_idx,
                             input logic [bba_pkg::APB_DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bba_pkg::APB_ADDR_W'(reg_idx) << bba_pkg::REG_SEL_BIT;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == bba_pkg::REG_LEVEL_COUNT) begin
            level_cnt_q = value[bba_pkg::LEVEL_W-1:0];
        end else begin
            leaf_q = value[bba_pkg::LEAF_W-1:0];
        end
    endtask

    // Request side: a beat stays on the bus until taken, then a drawn gap follows.
    always @(posedge i_clk) begin : drive_requests
        t_req_beat beat;
        t_reply    reply;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                beat = '{req_if.opcode, req_if.request_bytes, req_if.free_node};
                reply = serve_request(beat);
                due_replies.push_back(reply);
                if (reply.status == bba_pkg::STATUS_OK) begin
                    if (beat.opcode == bba_pkg::OP_ALLOC) begin
                        held_nodes.push_back(reply.node_index);
                    end else begin
                        for (int i = 0; i < held_nodes.size(); i++) begin
                            if (held_nodes[i] == reply.node_index) begin
                                held_nodes.delete(i);
                                break;
                            end
                        end
                    end
                end
            end
            if (!req_if.valid || req_if.ready) begin
                if (send_wait != 0) begin
                    send_wait--;
                    req_if.valid <= 1'b0;
                end else if (req_backlog.size() != 0) begin
                    beat = req_backlog.pop_front();
                    req_if.valid         <= 1'b1;
                    req_if.opcode        <= beat.opcode;
                    req_if.request_bytes <= beat.request_bytes;
                    req_if.free_node     <= beat.free_node;
                    if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
                    send_wait = send_calm ? 0 : $urandom_range(0, 7);
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Reply side: compare each beat with the oldest prediction, then stall a while.
    always @(posedge i_clk) begin : check_replies
        t_reply want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            reply_wait = 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                replies_seen++;
                if (due_replies.size() == 0) begin
                    $display("%0t: unexpected reply, expected none, got %0d/%0d/%0d",
                             $time, rsp_if.status, rsp_if.node_index,
                             rsp_if.byte_offset);
                    errors++;
                end else begin
                    want = due_replies.pop_front();
                    if (rsp_if.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, rsp_if.status);
                        errors++;
                    end
                    if (rsp_if.node_index !== want.node_index) begin
                        $display("%0t: node_index expected %0d got %0d",
                                 $time, want.node_index, rsp_if.node_index);
                        errors++;
                    end
                    if (rsp_if.byte_offset !== want.byte_offset) begin
                        $display("%0t: byte_offset expected 0x%08h got 0x%08h",
                                 $time, want.byte_offset, rsp_if.byte_offset);
                        errors++;
                    end
                end
                // Two long stalls let the block fill up and push back on requests.
                if (replies_seen == 40 || replies_seen == 900) begin
                    reply_wait = LONG_HOLD;
                end else begin
                    if ($urandom_range(0, 31) == 0) reply_calm = !reply_calm;
                    reply_wait = reply_calm ? 0 : $urandom_range(0, 7);
                end
            end else if (reply_wait != 0) begin
                reply_wait--;
            end
            rsp_if.ready <= (reply_wait == 0);
        end
    end

    initial begin
        int unsigned     levels;
        int unsigned     pick;
        int unsigned     target;
        longint unsigned span;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned need;
        t_req_beat       beat;

        req_if.valid         = 1'b0;
        req_if.opcode        = bba_pkg::OP_ALLOC;
        req_if.request_bytes = '0;
        req_if.free_node     = '0;
        rsp_if.ready         = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        i_rst_n              = 1'b0;

        foreach (free_map[i]) free_map[i] = 1'b0;
        free_map[1] = 1'b1;
        level_cnt_q = bba_pkg::LEVEL_COUNT_RESET;
        leaf_q      = bba_pkg::LEAF_BYTES_RESET;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on the reset configuration: eight levels of 64-byte leaves.
        push_beat(alloc_beat(0));
        push_beat(alloc_beat(60));
        push_beat(alloc_beat(61));
        push_beat(alloc_beat(8188));
        push_beat(alloc_beat(8189));
        push_beat(alloc_beat(24'hFF_FFFF));
        push_beat(release_beat(0));
        push_beat(release_beat(256));
        push_beat(release_beat(15'h7FFF));
        push_beat(release_beat(255));
        push_beat(release_beat(128));
        push_beat(release_beat(129));
        push_beat(release_beat(65));
        push_beat(release_beat(255));
        push_beat(alloc_beat(8188));
        push_beat(release_beat(1));
        push_beat(alloc_beat(0));

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            write_reg(bba_pkg::REG_LEVEL_COUNT, bba_pkg::APB_DATA_W'(PHASE_LEVELS[p]));
            write_reg(bba_pkg::REG_LEAF_BYTES, bba_pkg::APB_DATA_W'(PHASE_LEAF[p]));
            levels = tree_depth();
            for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45 && held_nodes.size() != 0) begin
                    beat = release_beat(held_nodes[$urandom_range(0, held_nodes.size() - 1)]);
                end else if (pick < 50) begin
                    beat = release_beat($urandom_range(1, (1 << levels) - 1));
                end else if (pick < 54) begin
                    beat = release_beat($urandom);
                end else if (pick < 58) begin
                    beat = alloc_beat($urandom);
                end else begin
                    // Size the request to land on one level, leaning to the deep end.
                    if ($urandom_range(0, 1) != 0) begin
                        target = $urandom_range(1, levels);
                    end else begin
                        target = levels - $urandom_range(0, (levels > 3) ? 3 : levels - 1);
                    end
                    span = 64'(leaf_q) << (levels - target);
                    hi = (span > MAX_NEED) ? MAX_NEED : span;
                    lo = (target == levels) ? 0 : span / 2 + 1;
                    if (lo > hi) lo = hi;
                    need = $urandom_range(32'(hi), 32'(lo));
                    beat = alloc_beat((need > HEADER_BYTES) ? need - HEADER_BYTES : 0);
                end
                push_beat(beat);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0 && due_replies.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
